// File: rtl/smf_pkg.sv
`timescale 1ns / 1ps
package smf_pkg;

	localparam int MAX_WINDOW = 16;
	localparam int READING_W  = 16;
	localparam int VALUE_W    = 17;
	localparam int COUNT_W    = 5;
	localparam int IDX_W      = 4;

	// Register word index, taken from paddr[2].
	localparam logic REG_SAMPLE_COUNT = 1'b0;
	localparam logic REG_INTERLEAVE   = 1'b1;

	// What one cell hands to its right neighbor.
	typedef struct packed {
		logic                 gt;
		logic [READING_W-1:0] value;
	} cell_link_t;

endpackage

// File: rtl/smf_cell.sv
`timescale 1ns / 1ps
module smf_cell
	import smf_pkg::*;
(
	input  logic                 clk,
	input  logic                 insert,
	input  logic                 occupied,
	input  logic [READING_W-1:0] reading,
	input  cell_link_t           left,
	output cell_link_t           right,
	output logic [READING_W-1:0] value,
	output logic [READING_W-1:0] value_next
);

	logic [READING_W-1:0] value_q;
	logic                 gt;

	assign gt = occupied && (value_q > reading);

	// The chain stays sorted: a cell takes its left neighbor's word when that one is
	// pushed right, the new reading when it is the insertion point, and otherwise keeps.
	always_comb begin
		priority if (left.gt) begin
			value_next = left.value;
		end else if (gt || !occupied) begin
			value_next = reading;
		end else begin
			value_next = value_q;
		end
	end

	always_ff @(posedge clk) begin
		if (insert) begin
			value_q <= value_next;
		end
	end

	assign right.gt    = gt;
	assign right.value = value_q;
	assign value       = value_q;

endmodule

// File: rtl/sensor_median_filter_core.sv
// Median filter over raw sensor range readings.
// Input channel: in_valid / in_stall with one 16-bit reading per word.
// Output channel: out_valid / out_stall with filtered_value (17-bit signed)
// and value_changed.
// Configuration: APB write to byte 0 sets sample_count (window N), to byte 4
// sets interleave_mode. Write only while the block is idle.
// With N of one every reading gives a result. In batch mode only the reading
// that completes a window gives a result, the upper median. In interleave mode
// every word gives a result: the reading is stored until N are held, then the
// next word evaluates the median and empties the store.
// Readings are kept in a sorted row of 16 cells, one insertion per cycle, so
// a word is accepted every cycle unless in_stall is raised, and its result is
// registered and appears in the cycle after acceptance. Each insertion is the
// single compare-and-shift step of the cell row plus the median select.
// Reset empties the window, sets the value to -1, N to one and batch mode.
// While a result waits in the output register under out_stall, in_stall is
// raised; a result taken in the same cycle frees the block for the next word.
`timescale 1ns / 1ps
module sensor_median_filter_core
	import smf_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [2:0]                paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [READING_W-1:0]      reading,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [VALUE_W-1:0] filtered_value,
	output logic                      value_changed
);

	logic [COUNT_W-1:0]        sample_count_q;
	logic                      interleave_q;
	logic [COUNT_W-1:0]        fill_q;
	logic signed [VALUE_W-1:0] cur_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] filtered_value_q;
	logic                      value_changed_q;

	logic                      accept;
	logic                      cfg_write;
	logic [COUNT_W-1:0]        win;
	logic [COUNT_W-1:0]        eff;
	logic [COUNT_W-1:0]        fill_d;
	logic                      emit;
	logic                      insert;
	logic signed [VALUE_W-1:0] next_val;

	cell_link_t                link [MAX_WINDOW+1];
	logic [READING_W-1:0]      cell_val [MAX_WINDOW];
	logic [READING_W-1:0]      cell_next [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]     occupied;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= COUNT_W'(1);
			interleave_q   <= 1'b0;
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_SAMPLE_COUNT: sample_count_q <= pwdata[COUNT_W-1:0];
				REG_INTERLEAVE:   interleave_q   <= pwdata[0];
				default:          sample_count_q <= sample_count_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SAMPLE_COUNT: prdata = {{(32-COUNT_W){1'b0}}, sample_count_q};
			REG_INTERLEAVE:   prdata = {31'd0, interleave_q};
			default:          prdata = 32'd0;
		endcase
	end

	// Window length, a zero count acting as one and large counts clamped.
	always_comb begin
		priority if (sample_count_q == '0) begin
			win = COUNT_W'(1);
		end else if (sample_count_q > COUNT_W'(MAX_WINDOW)) begin
			win = COUNT_W'(MAX_WINDOW);
		end else begin
			win = sample_count_q;
		end
	end

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	genvar gi;
	assign link[0] = '0;
	generate
		for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
			assign occupied[gi] = COUNT_W'(gi) < eff;
			smf_cell u_cell (
				.clk        (clk),
				.insert     (insert),
				.occupied   (occupied[gi]),
				.reading    (reading),
				.left       (link[gi]),
				.right      (link[gi+1]),
				.value      (cell_val[gi]),
				.value_next (cell_next[gi])
			);
		end
	endgenerate

	always_comb begin
		next_val = cur_q;
		emit     = 1'b1;
		insert   = 1'b0;
		fill_d   = fill_q;
		eff      = fill_q;
		priority if (win <= COUNT_W'(1)) begin
			next_val = {1'b0, reading};
		end else if (interleave_q) begin
			if (fill_q < win) begin
				insert = accept;
				fill_d = fill_q + COUNT_W'(1);
			end else begin
				next_val = {1'b0, cell_val[fill_q[IDX_W:1]]};
				fill_d   = '0;
			end
		end else begin
			// A window shrunk to or below the fill level starts over.
			if (fill_q >= win) begin
				eff = '0;
			end
			insert = accept;
			if (eff + COUNT_W'(1) >= win) begin
				next_val = {1'b0, cell_next[win[IDX_W:1]]};
				fill_d   = '0;
			end else begin
				fill_d = eff + COUNT_W'(1);
				emit   = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			cur_q       <= -VALUE_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q <= fill_d;
				if (emit) begin
					cur_q <= next_val;
				end
			end
			if (accept && emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			filtered_value_q <= next_val;
			value_changed_q  <= (next_val != cur_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign filtered_value = filtered_value_q;
	assign value_changed  = value_changed_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= COUNT_W'(MAX_WINDOW))
		else $error("fill level beyond window storage");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall))
		else $error("input stalled without a held result");

	a_direct_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && win <= COUNT_W'(1)) |=> (out_valid_q && !value_changed_q
		|| out_valid_q && value_changed_q))
		else $error("unfiltered word gave no result");

	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && emit) |=> (value_changed_q == (filtered_value_q != $past(cur_q))))
		else $error("change flag disagrees with value");

endmodule
